### rtl/core/lens_point_distortion_defines.svh
// assertion macros for the lens point distortion block
`ifndef LENS_POINT_DISTORTION_DEFINES_SVH
`define LENS_POINT_DISTORTION_DEFINES_SVH

`ifndef ASSERT_OFF
`define LPD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lens point distortion assertion failed");
`define LPD_ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("lens point distortion forbidden condition seen");
`else
`define LPD_ASSERT(lbl, clk, rst, prop)
`define LPD_ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

### rtl/core/lpd_pkg.sv
// package: formats, widths, register codes and rounding helpers for lens point distortion
`timescale 1ns / 1ps
`default_nettype none

package lpd_pkg;

  localparam int COORD_W = 18;
  localparam int COEF_W  = 24;
  localparam int FRAC_C  = COORD_W - 3;
  localparam int FRAC_K  = COEF_W - 4;
  localparam int CFG_IDX_W = 3;

  localparam int SQ_W    = COORD_W + 3;
  localparam int XY2_W   = COORD_W + 4;
  localparam int R2_W    = COORD_W + 4;
  localparam int AX_W    = COORD_W + 5;
  localparam int R4_W    = COORD_W + 9;
  localparam int R6_W    = COORD_W + 14;
  localparam int K1R2_W  = COORD_W + 7;
  localparam int K2R4_W  = COORD_W + 12;
  localparam int TP_W    = COORD_W + 8;
  localparam int TAN_W   = COORD_W + 9;
  localparam int RAD_W   = COORD_W + 17;
  localparam int OUT_W   = COORD_W + 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_K1 = 3'd0,
    REG_K2 = 3'd1,
    REG_P1 = 3'd2,
    REG_P2 = 3'd3,
    REG_K3 = 3'd4
  } lpd_reg_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] k1;
    logic signed [COEF_W-1:0] k2;
    logic signed [COEF_W-1:0] p1;
    logic signed [COEF_W-1:0] p2;
    logic signed [COEF_W-1:0] k3;
  } lpd_coef_t;

  localparam logic signed [63:0] HALF_C = 64'sd1 <<< (FRAC_C - 1);
  localparam logic signed [63:0] HALF_K = 64'sd1 <<< (FRAC_K - 1);

  // round to nearest, ties away from zero
  function automatic logic signed [63:0] rnd_c(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + HALF_C - $signed({63'b0, p[63]});
    return t >>> FRAC_C;
  endfunction

  function automatic logic signed [63:0] rnd_k(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + HALF_K - $signed({63'b0, p[63]});
    return t >>> FRAC_K;
  endfunction

endpackage

`default_nettype wire

### rtl/core/lpd_ifs.sv
// interfaces: point input, distorted point output and coefficient write channels
`timescale 1ns / 1ps
`default_nettype none

interface lpd_point_if;
  logic                                valid;
  logic                                ready;
  logic signed [lpd_pkg::COORD_W-1:0]  x_in;
  logic signed [lpd_pkg::COORD_W-1:0]  y_in;
  modport source (output valid, output x_in, output y_in, input ready);
  modport sink   (input valid, input x_in, input y_in, output ready);
endinterface

interface lpd_dist_if;
  logic                                valid;
  logic                                ready;
  logic signed [lpd_pkg::COORD_W-1:0]  x_out;
  logic signed [lpd_pkg::COORD_W-1:0]  y_out;
  logic                                overflow;
  modport source (output valid, output x_out, output y_out, output overflow, input ready);
  modport sink   (input valid, input x_out, input y_out, input overflow, output ready);
endinterface

interface lpd_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [lpd_pkg::CFG_IDX_W-1:0]        index;
  logic [lpd_pkg::COEF_W-1:0]           data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/lpd_coef_regs.sv
// coefficient register file written through the configuration channel
`timescale 1ns / 1ps
`default_nettype none

module lpd_coef_regs (
  input  wire                 clk,
  input  wire                 rst,
  lpd_cfg_if.sink             cfg,
  output lpd_pkg::lpd_coef_t  coef
);
  import lpd_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_K1:  coef.k1 <= cfg.data;
        REG_K2:  coef.k2 <= cfg.data;
        REG_P1:  coef.p1 <= cfg.data;
        REG_P2:  coef.p2 <= cfg.data;
        REG_K3:  coef.k3 <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/lens_point_distortion.sv
// top level: nine-stage pipelined five-coefficient lens distortion of one point
`timescale 1ns / 1ps
`default_nettype none
`include "lens_point_distortion_defines.svh"

// Maps a normalized Q2.15 point through radial (k1, k2, k3) and tangential (p1, p2)
// lens distortion with Q3.20 coefficients and gives the saturated Q2.15 result
// with an overflow flag. One point is accepted every cycle unless an output stall
// holds the pipeline; each point passes the nine register stages of the multiplier
// chain (x*x, r2*r2, r4*r2, k3*r6, radial*x and the adds between). Every stage has
// its own enable, so a stall on the output fills empty stages before the input side
// sees ready drop. Coefficients reset to zero. The user must write them through the
// configuration channel only while no point is in flight; the block does not enforce it.
module lens_point_distortion (
  input  wire        clk,
  input  wire        rst,
  lpd_point_if.sink  point,
  lpd_dist_if.source distorted,
  lpd_cfg_if.sink    cfg
);
  import lpd_pkg::*;

  localparam int NST = 9;
  localparam logic signed [RAD_W-1:0] ONE_RAD = RAD_W'(1) <<< FRAC_C;
  localparam logic signed [OUT_W-1:0] CMAX =
    {{(OUT_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] CMIN = ~CMAX;

  lpd_coef_t coef;

  lpd_coef_regs u_coef (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .coef (coef)
  );

  logic [NST:1] v;
  logic [NST:1] en;

  always_comb begin
    en[NST] = !v[NST] || distorted.ready;
    for (int k = NST - 1; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign point.ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= point.valid;
      for (int k = 2; k <= NST; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage registers
  logic signed [COORD_W-1:0] x1, y1, x2, y2, x3, y3, x4, y4, x5, y5, x6, y6, x7, y7;
  logic signed [SQ_W-1:0]    xx2, yy2;
  logic signed [XY2_W-1:0]   xy2_2, xy2_3;
  logic signed [R2_W-1:0]    r2_3, r2_4;
  logic signed [AX_W-1:0]    ax3, ay3;
  logic signed [R4_W-1:0]    r4_4;
  logic signed [K1R2_W-1:0]  k1r2_4;
  logic signed [TP_W-1:0]    tpxa4, tpxb4, tpya4, tpyb4;
  logic signed [R6_W-1:0]    r6_5;
  logic signed [K2R4_W-1:0]  k2r4_5;
  logic signed [RAD_W-1:0]   part5, part6, k3r6_6, rad7;
  logic signed [TAN_W-1:0]   tx5, ty5, tx6, ty6, tx7, ty7, tx8, ty8;
  logic signed [OUT_W-1:0]   cx8, cy8;
  logic signed [COORD_W-1:0] xo9, yo9;
  logic                      ov9;

  // products, each registered before the next multiply
  logic signed [2*COORD_W-1:0]       xx_p, yy_p, xy_p;
  logic signed [2*R2_W-1:0]          r4_p;
  logic signed [COEF_W+R2_W-1:0]     k1r2_p;
  logic signed [COEF_W+XY2_W-1:0]    p1xy_p, p2xy_p;
  logic signed [COEF_W+AX_W-1:0]     p2ax_p, p1ay_p;
  logic signed [R4_W+R2_W-1:0]       r6_p;
  logic signed [COEF_W+R4_W-1:0]     k2r4_p;
  logic signed [COEF_W+R6_W-1:0]     k3r6_p;
  logic signed [RAD_W+COORD_W-1:0]   cx_p, cy_p;
  logic signed [OUT_W-1:0]           xs, ys;

  assign xx_p   = x1 * x1;
  assign yy_p   = y1 * y1;
  assign xy_p   = x1 * y1;
  assign r4_p   = r2_3 * r2_3;
  assign k1r2_p = coef.k1 * r2_3;
  assign p1xy_p = coef.p1 * xy2_3;
  assign p2ax_p = coef.p2 * ax3;
  assign p1ay_p = coef.p1 * ay3;
  assign p2xy_p = coef.p2 * xy2_3;
  assign r6_p   = r4_4 * r2_4;
  assign k2r4_p = coef.k2 * r4_4;
  assign k3r6_p = coef.k3 * r6_5;
  assign cx_p   = rad7 * x7;
  assign cy_p   = rad7 * y7;
  assign xs     = cx8 + OUT_W'(tx8);
  assign ys     = cy8 + OUT_W'(ty8);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      x1 <= point.x_in;
      y1 <= point.y_in;
    end
    if (en[2]) begin
      xx2   <= SQ_W'(rnd_c(64'(xx_p)));
      yy2   <= SQ_W'(rnd_c(64'(yy_p)));
      xy2_2 <= XY2_W'(rnd_c(64'(xy_p))) <<< 1;
      x2    <= x1;
      y2    <= y1;
    end
    if (en[3]) begin
      r2_3  <= R2_W'(xx2) + R2_W'(yy2);
      ax3   <= AX_W'(xx2) + AX_W'(yy2) + (AX_W'(xx2) <<< 1);
      ay3   <= AX_W'(xx2) + AX_W'(yy2) + (AX_W'(yy2) <<< 1);
      xy2_3 <= xy2_2;
      x3    <= x2;
      y3    <= y2;
    end
    if (en[4]) begin
      r4_4   <= R4_W'(rnd_c(64'(r4_p)));
      r2_4   <= r2_3;
      k1r2_4 <= K1R2_W'(rnd_k(64'(k1r2_p)));
      tpxa4  <= TP_W'(rnd_k(64'(p1xy_p)));
      tpxb4  <= TP_W'(rnd_k(64'(p2ax_p)));
      tpya4  <= TP_W'(rnd_k(64'(p1ay_p)));
      tpyb4  <= TP_W'(rnd_k(64'(p2xy_p)));
      x4     <= x3;
      y4     <= y3;
    end
    if (en[5]) begin
      r6_5   <= R6_W'(rnd_c(64'(r6_p)));
      k2r4_5 <= K2R4_W'(rnd_k(64'(k2r4_p)));
      part5  <= ONE_RAD + RAD_W'(k1r2_4);
      tx5    <= TAN_W'(tpxa4) + TAN_W'(tpxb4);
      ty5    <= TAN_W'(tpya4) + TAN_W'(tpyb4);
      x5     <= x4;
      y5     <= y4;
    end
    if (en[6]) begin
      k3r6_6 <= RAD_W'(rnd_k(64'(k3r6_p)));
      part6  <= part5 + RAD_W'(k2r4_5);
      tx6    <= tx5;
      ty6    <= ty5;
      x6     <= x5;
      y6     <= y5;
    end
    if (en[7]) begin
      rad7 <= part6 + k3r6_6;
      tx7  <= tx6;
      ty7  <= ty6;
      x7   <= x6;
      y7   <= y6;
    end
    if (en[8]) begin
      cx8 <= OUT_W'(rnd_c(64'(cx_p)));
      cy8 <= OUT_W'(rnd_c(64'(cy_p)));
      tx8 <= tx7;
      ty8 <= ty7;
    end
    if (en[9]) begin
      xo9 <= (xs > CMAX) ? COORD_W'(CMAX) : (xs < CMIN) ? COORD_W'(CMIN) : COORD_W'(xs);
      yo9 <= (ys > CMAX) ? COORD_W'(CMAX) : (ys < CMIN) ? COORD_W'(CMIN) : COORD_W'(ys);
      ov9 <= (xs > CMAX) || (xs < CMIN) || (ys > CMAX) || (ys < CMIN);
    end
  end

  assign distorted.valid    = v[NST];
  assign distorted.x_out    = xo9;
  assign distorted.y_out    = yo9;
  assign distorted.overflow = ov9;

  `LPD_ASSERT(a_ready_when_drained, clk, rst, distorted.ready |-> point.ready)
  `LPD_ASSERT(a_stage_hold, clk, rst, (v[4] && !en[4]) |=> v[4])
  `LPD_ASSERT_NEVER(a_ovf_only_at_limit, clk, rst,
    distorted.valid && distorted.overflow &&
    distorted.x_out != COORD_W'(CMAX) && distorted.x_out != COORD_W'(CMIN) &&
    distorted.y_out != COORD_W'(CMAX) && distorted.y_out != COORD_W'(CMIN))

endmodule

`default_nettype wire

### tb/sv/lens_point_distortion_tb.sv
// self-checking testbench for lens_point_distortion: predicted distortion vs pipeline output
`timescale 1ns / 1ps

module lens_point_distortion_tb;
  import lpd_pkg::*;

  localparam int     PIPE_LATENCY = 9;
  localparam int     CYCLE_LIMIT  = 400000;
  localparam int     PRINT_LIMIT  = 40;
  localparam longint COORD_MAX    = (longint'(1) <<< (COORD_W - 1)) - 1;
  localparam longint COORD_MIN    = -COORD_MAX - 1;
  localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic signed [COEF_W-1:0] COEF_QUARTER = COEF_W'(1) <<< (FRAC_K - 2);
  localparam logic signed [COORD_W-1:0] PT_MAX  = COORD_W'(COORD_MAX);
  localparam logic signed [COORD_W-1:0] PT_MIN  = COORD_W'(COORD_MIN);
  localparam logic signed [COORD_W-1:0] PT_ONE  = COORD_W'(1) <<< FRAC_C;
  localparam logic signed [COORD_W-1:0] PT_HALF = COORD_W'(1) <<< (FRAC_C - 1);

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      ovf;
  } dist_point_t;

  logic clk = 1'b0;
  logic rst;

  lpd_point_if point ();
  lpd_dist_if  distorted ();
  lpd_cfg_if   cfg ();

  lens_point_distortion uut (
    .clk       (clk),
    .rst       (rst),
    .point     (point),
    .distorted (distorted),
    .cfg       (cfg)
  );

  lpd_coef_t   lens_coef;
  dist_point_t pending_points[$];
  dist_point_t oldest_point;
  int          mismatch_count;
  int          cycle_count;
  bit          stall_enable;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // round(a*b / 2^sh), ties away from zero
  function automatic longint round_mul(input longint a, input longint b, input int sh);
    logic signed [127:0] pa;
    logic signed [127:0] pb;
    logic signed [127:0] prod;
    logic        [127:0] mag;
    logic                neg;
    pa   = 128'(a);
    pb   = 128'(b);
    prod = pa * pb;
    neg  = prod[127];
    mag  = neg ? -prod : prod;
    mag  = (mag + (128'd1 << (sh - 1))) >> sh;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint clamp_coord(input longint v, inout logic ovf);
    if (v > COORD_MAX) begin
      ovf = 1'b1;
      return COORD_MAX;
    end
    if (v < COORD_MIN) begin
      ovf = 1'b1;
      return COORD_MIN;
    end
    return v;
  endfunction

  function automatic dist_point_t distort_point(input logic signed [COORD_W-1:0] xin,
                                                input logic signed [COORD_W-1:0] yin);
    longint      x, y, k1, k2, k3, p1, p2;
    longint      xx, yy, xy2, r2, r4, r6, radial, tx, ty, xd, yd;
    logic        ovf;
    dist_point_t res;
    x  = longint'(xin);
    y  = longint'(yin);
    k1 = longint'(lens_coef.k1);
    k2 = longint'(lens_coef.k2);
    p1 = longint'(lens_coef.p1);
    p2 = longint'(lens_coef.p2);
    k3 = longint'(lens_coef.k3);
    xx  = round_mul(x, x, FRAC_C);
    yy  = round_mul(y, y, FRAC_C);
    xy2 = 2 * round_mul(x, y, FRAC_C);
    r2  = xx + yy;
    r4  = round_mul(r2, r2, FRAC_C);
    r6  = round_mul(r4, r2, FRAC_C);
    radial = (longint'(1) <<< FRAC_C) + round_mul(k1, r2, FRAC_K)
             + round_mul(k2, r4, FRAC_K) + round_mul(k3, r6, FRAC_K);
    tx = round_mul(p1, xy2, FRAC_K) + round_mul(p2, r2 + 2 * xx, FRAC_K);
    ty = round_mul(p1, r2 + 2 * yy, FRAC_K) + round_mul(p2, xy2, FRAC_K);
    ovf = 1'b0;
    xd  = clamp_coord(round_mul(radial, x, FRAC_C) + tx, ovf);
    yd  = clamp_coord(round_mul(radial, y, FRAC_C) + ty, ovf);
    res.x   = xd[COORD_W-1:0];
    res.y   = yd[COORD_W-1:0];
    res.ovf = ovf;
    return res;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("%0t mismatch %s: got %0d expected %0d", $time, field, got, want);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && distorted.valid && distorted.ready) begin
      if (pending_points.size() == 0) begin
        report_mismatch("result with no point pending, x_out",
                        longint'(distorted.x_out), 0);
      end else begin
        oldest_point = pending_points.pop_front();
        if (distorted.x_out !== oldest_point.x)
          report_mismatch("x_out", longint'(distorted.x_out), longint'(oldest_point.x));
        if (distorted.y_out !== oldest_point.y)
          report_mismatch("y_out", longint'(distorted.y_out), longint'(oldest_point.y));
        if (distorted.overflow !== oldest_point.ovf)
          report_mismatch("overflow", longint'(distorted.overflow),
                          longint'(oldest_point.ovf));
      end
    end
  end

  // output backpressure
  always @(negedge clk) begin
    distorted.ready = !stall_enable || ($urandom_range(99) >= 18);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[lens_point_distortion] ERROR");
    $finish;
  end

  task automatic send_point(input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y);
    while (stall_enable && $urandom_range(99) < 18) begin
      point.valid = 1'b0;
      @(negedge clk);
    end
    point.valid = 1'b1;
    point.x_in  = x;
    point.y_in  = y;
    @(posedge clk);
    while (!point.ready) @(posedge clk);
    pending_points.push_back(distort_point(x, y));
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    point.valid = 1'b0;
    while (pending_points.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_coef(input logic [CFG_IDX_W-1:0] index,
                            input logic signed [COEF_W-1:0] data);
    cfg.valid = 1'b1;
    cfg.index = index;
    cfg.data  = data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (index)
      REG_K1:  lens_coef.k1 = data;
      REG_K2:  lens_coef.k2 = data;
      REG_P1:  lens_coef.p1 = data;
      REG_P2:  lens_coef.p2 = data;
      REG_K3:  lens_coef.k3 = data;
      default: ;
    endcase
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic load_coefs(input logic signed [COEF_W-1:0] k1, input logic signed [COEF_W-1:0] k2,
                            input logic signed [COEF_W-1:0] p1, input logic signed [COEF_W-1:0] p2,
                            input logic signed [COEF_W-1:0] k3);
    wait_for_results();
    write_coef(REG_K1, k1);
    write_coef(REG_K2, k2);
    write_coef(REG_P1, p1);
    write_coef(REG_P2, p2);
    write_coef(REG_K3, k3);
  endtask

  function automatic logic signed [COORD_W-1:0] random_coord(input bit full_range);
    if (full_range)
      return COORD_W'($urandom);
    return COORD_W'(int'($urandom_range(2 * PT_ONE)) - PT_ONE);
  endfunction

  function automatic logic signed [COEF_W-1:0] random_coef(input int mag_log2);
    return COEF_W'(int'($urandom_range(1 << (mag_log2 + 1))) - (1 << mag_log2));
  endfunction

  function automatic logic signed [COEF_W-1:0] extreme_coef();
    case ($urandom_range(2))
      0:       return COEF_MAX;
      1:       return COEF_MIN;
      default: return '0;
    endcase
  endfunction

  // zero coefficients pass the point through unchanged
  task automatic test_identity_after_reset();
    send_point('0, '0);
    send_point(PT_MAX, PT_MAX);
    send_point(PT_MIN, PT_MIN);
    send_point(PT_MAX, PT_MIN);
    send_point(PT_MIN, PT_MAX);
    send_point(COORD_W'(1), -COORD_W'(1));
  endtask

  task automatic test_extreme_coefficients();
    load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    send_point(PT_MAX, PT_MAX);
    send_point(PT_MIN, PT_MAX);
    send_point(PT_HALF, -PT_HALF);
    load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    send_point(PT_MIN, PT_MIN);
    send_point(PT_MAX, PT_MIN);
    send_point(-PT_HALF, PT_HALF);
  endtask

  task automatic test_single_coefficients();
    lpd_reg_t sel;
    for (int i = 0; i <= int'(REG_K3); i++) begin
      sel = lpd_reg_t'(i);
      load_coefs('0, '0, '0, '0, '0);
      write_coef(sel, COEF_QUARTER);
      send_point(PT_ONE, PT_HALF);
      send_point(-PT_HALF, PT_ONE);
    end
  endtask

  // writes to indexes past the last register must leave the coefficients alone
  task automatic test_unknown_register_index();
    load_coefs(COEF_QUARTER, '0, '0, '0, '0);
    for (int i = int'(REG_K3) + 1; i < (1 << CFG_IDX_W); i++)
      write_coef(CFG_IDX_W'(i), COEF_W'($urandom));
    send_point(PT_ONE, -PT_ONE);
    send_point(PT_HALF, PT_ONE);
  endtask

  task automatic test_random_points(input int count, input int coef_mode, input bit pause_midway);
    case (coef_mode)
      0: load_coefs(random_coef(FRAC_K - 1), random_coef(FRAC_K - 2), random_coef(FRAC_K - 6),
                    random_coef(FRAC_K - 6), random_coef(FRAC_K - 3));
      1: load_coefs(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
                    COEF_W'($urandom), COEF_W'($urandom));
      default: load_coefs(extreme_coef(), extreme_coef(), extreme_coef(),
                          extreme_coef(), extreme_coef());
    endcase
    for (int i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2)
        wait_for_results();
      send_point(random_coord($urandom_range(99) < 25), random_coord($urandom_range(99) < 25));
    end
  endtask

  task automatic test_back_to_back(input int count);
    stall_enable = 1'b0;
    test_random_points(count, 0, 1'b0);
    wait_for_results();
    stall_enable = 1'b1;
  endtask

  task automatic test_drain_pause(input int count);
    test_random_points(count, 0, 1'b1);
  endtask

  initial begin
    rst             = 1'b1;
    point.valid     = 1'b0;
    point.x_in      = '0;
    point.y_in      = '0;
    cfg.valid       = 1'b0;
    cfg.index       = '0;
    cfg.data        = '0;
    distorted.ready = 1'b0;
    lens_coef       = '0;
    mismatch_count  = 0;
    stall_enable    = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_identity_after_reset();
    test_extreme_coefficients();
    test_single_coefficients();
    test_unknown_register_index();
    test_random_points(125, 0, 1'b0);
    test_random_points(125, 0, 1'b0);
    test_random_points(125, 1, 1'b0);
    test_random_points(100, 2, 1'b0);
    test_back_to_back(150);
    test_drain_pause(125);
    load_coefs('0, '0, '0, '0, '0);
    send_point(PT_MAX, PT_MIN);
    wait_for_results();

    if (mismatch_count == 0)
      $display("[lens_point_distortion] OK");
    else
      $display("[lens_point_distortion] ERROR");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/lpd_pkg.sv
rtl/core/lpd_ifs.sv
rtl/core/lpd_coef_regs.sv
rtl/core/lens_point_distortion.sv
tb/sv/lens_point_distortion_tb.sv
